@@ hdl/lmcfw_pkg.sv @@
// Package for the LED matrix chain frame writer.
// Holds command codes, opcodes, the sequencer state type and the shared frame request struct.
// No dependencies.
package lmcfw_pkg;

   typedef logic [3:0] count_cfg_type;

   localparam count_cfg_type RESET_COUNT = 4'd8;

   localparam logic [2:0] CMD_SET_LED    = 3'd0;
   localparam logic [2:0] CMD_SET_ROW    = 3'd1;
   localparam logic [2:0] CMD_SET_COLUMN = 3'd2;
   localparam logic [2:0] CMD_CLEAR      = 3'd3;
   localparam logic [2:0] CMD_SHUTDOWN   = 3'd4;
   localparam logic [2:0] CMD_INTENSITY  = 3'd5;
   localparam logic [2:0] CMD_SCAN_LIMIT = 3'd6;

   localparam logic [7:0] OPC_INTENSITY = 8'd10;
   localparam logic [7:0] OPC_SCANLIMIT = 8'd11;
   localparam logic [7:0] OPC_SHUTDOWN  = 8'd12;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MODIFY,
      ST_EMIT
   } state_type;

   // one frame to send: target device, its word, and whether it closes the command
   typedef struct packed {
      logic [2:0]  dev;
      logic [15:0] word;
      logic        last_frame;
   } frame_req_type;

endpackage

@@ hdl/lmcfw_ifs.sv @@
// Valid/ready channel interfaces of the LED matrix chain frame writer.
// Command channel and frame word channel; no dependencies.
interface lmcfw_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [2:0] device;
   logic [2:0] row;
   logic [2:0] column;
   logic [7:0] pattern;
   logic       flag;

   modport source (output valid, cmd, device, row, column, pattern, flag, input ready);
   modport sink   (input valid, cmd, device, row, column, pattern, flag, output ready);
endinterface

interface lmcfw_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] frame_word;
   logic [2:0]  word_device;
   logic        frame_end;
   logic        last;

   modport source (output valid, frame_word, word_device, frame_end, last, input ready);
   modport sink   (input valid, frame_word, word_device, frame_end, last, output ready);
endinterface

@@ hdl/led_matrix_chain_frame_writer.sv @@
// LED matrix chain frame writer: row commands update shadow rows, and every valid command
// sends chain frames. Per frame: read row, modify row, then one word per device per cycle
// while the output is not stalled. Set column and clear send eight frames, one per row.
// Not ready while a command is in work. Reset: device_count 8, shadow rows read zero.
// Depends on lmcfw_pkg, lmcfw_ifs, lmcfw_shadow and lmcfw_frame_emit.
module led_matrix_chain_frame_writer #(
   parameter int MAX_DEVICES = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   lmcfw_req_if.sink                req_bus,
   lmcfw_rsp_if.source              rsp_bus,
   input  logic                     csr_write_en,
   input  lmcfw_pkg::count_cfg_type csr_write_data
);
   import lmcfw_pkg::*;

   localparam int DEPTH = MAX_DEVICES * 8;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_DEVICES + 1);
   localparam logic [4:0] MaxCount = 5'(MAX_DEVICES);

   state_type     state_ff, state_in;
   logic [2:0]    step_ff, step_in;
   count_cfg_type count_cfg_ff;
   logic [CW-1:0] count_eff;
   logic [CW-1:0] count_ff;
   logic [2:0]    cmd_ff, dev_ff, row_ff, col_ff;
   logic [7:0]    pat_ff;
   logic          flag_ff;

   logic          accept;
   logic          dev_ok, cmd_ok;
   logic          multi_row, last_step;
   logic [2:0]    cur_row;
   logic [AW-1:0] row_addr;
   logic [7:0]    old_byte, new_byte, mask, opcode, data;
   logic          bit_on, row_write;
   logic          rd_en, wr_en, emit_start, emit_done;
   frame_req_type frame_req;

   // csr
   always_ff @(posedge clock) begin
      if (reset) begin
         count_cfg_ff <= RESET_COUNT;
      end else if (csr_write_en) begin
         count_cfg_ff <= csr_write_data;
      end
   end

   assign count_eff = (count_cfg_ff == '0 || 5'(count_cfg_ff) > MaxCount)
                      ? CW'(MAX_DEVICES) : CW'(count_cfg_ff);

   // command check
   assign accept = req_bus.valid && req_bus.ready;
   assign dev_ok = 5'(req_bus.device) < 5'(count_eff);

   always_comb begin
      unique case (req_bus.cmd)
         CMD_SET_LED, CMD_SET_ROW, CMD_SET_COLUMN, CMD_CLEAR, CMD_SHUTDOWN: cmd_ok = 1'b1;
         CMD_INTENSITY:  cmd_ok = (req_bus.pattern[7:4] == 4'd0);
         CMD_SCAN_LIMIT: cmd_ok = (req_bus.pattern[7:3] == 5'd0);
         default:        cmd_ok = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_bus.cmd;
         dev_ff   <= req_bus.device;
         row_ff   <= req_bus.row;
         col_ff   <= req_bus.column;
         pat_ff   <= req_bus.pattern;
         flag_ff  <= req_bus.flag;
         count_ff <= count_eff;
      end
   end

   // row modify
   assign multi_row = (cmd_ff == CMD_SET_COLUMN) || (cmd_ff == CMD_CLEAR);
   assign last_step = !multi_row || (step_ff == 3'd7);
   assign cur_row   = multi_row ? step_ff : row_ff;
   assign row_addr  = AW'({dev_ff, cur_row});
   assign mask      = 8'h80 >> col_ff;
   assign bit_on    = (cmd_ff == CMD_SET_COLUMN) ? pat_ff[~step_ff] : flag_ff;

   always_comb begin
      row_write = 1'b1;
      new_byte  = old_byte;
      opcode    = 8'(cur_row) + 8'd1;
      data      = pat_ff;
      unique case (cmd_ff)
         CMD_SET_LED, CMD_SET_COLUMN: begin
            new_byte = bit_on ? (old_byte | mask) : (old_byte & ~mask);
            data     = new_byte;
         end
         CMD_SET_ROW: begin
            new_byte = pat_ff;
            data     = pat_ff;
         end
         CMD_CLEAR: begin
            new_byte = 8'd0;
            data     = 8'd0;
         end
         CMD_SHUTDOWN: begin
            row_write = 1'b0;
            opcode    = OPC_SHUTDOWN;
            data      = {7'd0, ~flag_ff};
         end
         CMD_INTENSITY: begin
            row_write = 1'b0;
            opcode    = OPC_INTENSITY;
         end
         CMD_SCAN_LIMIT: begin
            row_write = 1'b0;
            opcode    = OPC_SCANLIMIT;
         end
         default: begin
            row_write = 1'b0;
         end
      endcase
   end

   assign frame_req.dev        = dev_ff;
   assign frame_req.word       = {opcode, data};
   assign frame_req.last_frame = last_step;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = 3'd0;
            if (accept && dev_ok && cmd_ok) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   state_in = ST_MODIFY;
         ST_MODIFY: state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_done) begin
               state_in = last_step ? ST_IDLE : ST_READ;
               step_in  = 3'(step_ff + 3'd1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = (state_ff == ST_IDLE);
      rd_en         = (state_ff == ST_READ);
      wr_en         = (state_ff == ST_MODIFY) && row_write;
      emit_start    = (state_ff == ST_MODIFY);
   end

   lmcfw_shadow #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_shadow (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (row_addr),
      .rd_data (old_byte),
      .wr_en   (wr_en),
      .wr_addr (row_addr),
      .wr_data (new_byte)
   );

   lmcfw_frame_emit #(
      .CW (CW)
   ) u_frame_emit (
      .clock     (clock),
      .reset     (reset),
      .start     (emit_start),
      .frame_req (frame_req),
      .count     (count_ff),
      .done      (emit_done),
      .rsp_bus   (rsp_bus)
   );

   a_last_on_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.last |-> rsp_bus.frame_end)
      else $error("last word not on frame end");

   a_bad_device_dropped: assert property (@(posedge clock) disable iff (reset)
      accept && !dev_ok |=> state_ff == ST_IDLE)
      else $error("out of range device started a command");

   a_final_frame_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && emit_done && last_step |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle after final frame");

endmodule

@@ hdl/lmcfw_shadow.sv @@
// Shadow row store: one byte per row of every device, registered read.
// Per-row valid bits make unwritten rows read as zero after reset.
// Depends on nothing but its parameters.
module lmcfw_shadow #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data
);

   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] row_valid_ff;
   logic [7:0]       mem_rd_ff;
   logic             vld_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_ff <= mem[rd_addr];
         vld_rd_ff <= row_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = vld_rd_ff ? mem_rd_ff : 8'd0;

endmodule

@@ hdl/lmcfw_frame_emit.sv @@
// Frame emitter: walks the chain from the last device down to device 0, one word
// per cycle into the output register unless stalled; no-op words for other devices.
// Depends on lmcfw_pkg and lmcfw_ifs.
module lmcfw_frame_emit #(
   parameter int CW = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  lmcfw_pkg::frame_req_type frame_req,
   input  logic [CW-1:0]          count,
   output logic                   done,
   lmcfw_rsp_if.source            rsp_bus
);
   import lmcfw_pkg::*;

   logic          busy_ff;
   logic [CW-1:0] dev_idx_ff;
   frame_req_type req_ff;
   logic          valid_ff;
   logic [15:0]   word_ff;
   logic [2:0]    word_dev_ff;
   logic          end_ff;
   logic          last_ff;
   logic          load;
   logic          at_zero;

   assign at_zero = (dev_idx_ff == '0);
   assign load    = busy_ff && (!valid_ff || rsp_bus.ready);
   assign done    = load && at_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dev_idx_ff <= CW'(count - CW'(1));
         req_ff     <= frame_req;
      end else if (load && !at_zero) begin
         dev_idx_ff <= CW'(dev_idx_ff - CW'(1));
      end
      if (load) begin
         word_ff     <= (5'(dev_idx_ff) == 5'(req_ff.dev)) ? req_ff.word : 16'd0;
         word_dev_ff <= 3'(dev_idx_ff);
         end_ff      <= at_zero;
         last_ff     <= at_zero && req_ff.last_frame;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.frame_word  = word_ff;
   assign rsp_bus.word_device = word_dev_ff;
   assign rsp_bus.frame_end   = end_ff;
   assign rsp_bus.last        = last_ff;

endmodule

@@ bench/tb_led_matrix_chain_frame_writer.sv @@
`timescale 1ns / 100ps
// Testbench for led_matrix_chain_frame_writer: drives commands and device counts, checks
// every frame word against a predictor of the shadow rows and the chain frame layout.
// Depends on lmcfw_pkg, lmcfw_ifs and the frame writer RTL.
module tb_led_matrix_chain_frame_writer;
   import lmcfw_pkg::*;

   localparam int MAX_DEVICES = 8;
   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = 100;
   localparam int LONG_STALL = 400;

   typedef struct packed {
      logic [2:0] cmd;
      logic [2:0] device;
      logic [2:0] row;
      logic [2:0] column;
      logic [7:0] pattern;
      logic       flag;
   } cmd_item_type;

   typedef struct packed {
      logic [15:0] word;
      logic [2:0]  dev;
      logic        frame_end;
      logic        last;
   } chain_word_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   count_cfg_type csr_write_data;

   lmcfw_req_if req_bus();
   lmcfw_rsp_if rsp_bus();

   led_matrix_chain_frame_writer #(
      .MAX_DEVICES(MAX_DEVICES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   cmd_item_type   pending_cmds[$];
   chain_word_type expected_words[$];
   chain_word_type cmd_words[$];
   logic [7:0]     shadow_mirror[64];
   count_cfg_type  count_mirror;

   int   cmds_queued;
   int   cmds_accepted;
   int   mismatches;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   stall_req;
   int   stall_ack;
   int   stall_left;
   logic req_taken;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // predictor
   function automatic void append_frame(int cnt, logic [2:0] dev, logic [7:0] opcode,
                                        logic [7:0] data);
      chain_word_type w;
      for (int d = cnt - 1; d >= 0; d--) begin
         w.word      = (d == dev) ? {opcode, data} : 16'h0000;
         w.dev       = 3'(d);
         w.frame_end = (d == 0);
         w.last      = 1'b0;
         cmd_words.push_back(w);
      end
   endfunction

   function automatic void led_update(int cnt, logic [2:0] dev, logic [2:0] row,
                                      logic [2:0] col, logic on);
      logic [5:0] idx;
      logic [7:0] mask;
      idx  = {dev, row};
      mask = 8'h80 >> col;
      if (on) begin
         shadow_mirror[idx] = shadow_mirror[idx] | mask;
      end else begin
         shadow_mirror[idx] = shadow_mirror[idx] & ~mask;
      end
      append_frame(cnt, dev, {5'd0, row} + 8'd1, shadow_mirror[idx]);
   endfunction

   function automatic void predict_command(cmd_item_type it);
      int cnt;
      cnt = (count_mirror == 0 || count_mirror > MAX_DEVICES) ? MAX_DEVICES : count_mirror;
      cmd_words.delete();
      if (it.device < cnt) begin
         case (it.cmd)
            CMD_SET_LED: begin
               led_update(cnt, it.device, it.row, it.column, it.flag);
            end
            CMD_SET_ROW: begin
               shadow_mirror[{it.device, it.row}] = it.pattern;
               append_frame(cnt, it.device, {5'd0, it.row} + 8'd1, it.pattern);
            end
            CMD_SET_COLUMN: begin
               for (int r = 0; r < 8; r++) begin
                  led_update(cnt, it.device, 3'(r), it.column, it.pattern[7 - r]);
               end
            end
            CMD_CLEAR: begin
               for (int r = 0; r < 8; r++) begin
                  shadow_mirror[{it.device, 3'(r)}] = 8'h00;
                  append_frame(cnt, it.device, 8'(r + 1), 8'h00);
               end
            end
            CMD_SHUTDOWN: begin
               append_frame(cnt, it.device, OPC_SHUTDOWN, it.flag ? 8'd0 : 8'd1);
            end
            CMD_INTENSITY: begin
               if (it.pattern < 16) append_frame(cnt, it.device, OPC_INTENSITY, it.pattern);
            end
            CMD_SCAN_LIMIT: begin
               if (it.pattern < 8) append_frame(cnt, it.device, OPC_SCANLIMIT, it.pattern);
            end
            default: ;
         endcase
      end
      if (cmd_words.size() != 0) cmd_words[cmd_words.size() - 1].last = 1'b1;
      foreach (cmd_words[i]) expected_words.push_back(cmd_words[i]);
   endfunction

   function automatic void check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                  act_val);
         mismatches++;
      end
   endfunction

   // stimulus helpers
   function automatic void send(logic [2:0] cmd, logic [2:0] dev, logic [2:0] row,
                                logic [2:0] col, logic [7:0] pat, logic flag);
      cmd_item_type it;
      it = {cmd, dev, row, col, pat, flag};
      pending_cmds.push_back(it);
      cmds_queued++;
   endfunction

   function automatic void send_random();
      int sel;
      logic [2:0] cmd;
      logic [7:0] pat;
      sel = $urandom_range(99);
      if (sel < 25)      cmd = CMD_SET_LED;
      else if (sel < 45) cmd = CMD_SET_ROW;
      else if (sel < 55) cmd = CMD_SET_COLUMN;
      else if (sel < 60) cmd = CMD_CLEAR;
      else if (sel < 70) cmd = CMD_SHUTDOWN;
      else if (sel < 82) cmd = CMD_INTENSITY;
      else if (sel < 94) cmd = CMD_SCAN_LIMIT;
      else               cmd = CMD_UNUSED;
      pat = 8'($urandom_range(255));
      if (cmd == CMD_INTENSITY && $urandom_range(4) != 0)  pat = 8'($urandom_range(15));
      if (cmd == CMD_SCAN_LIMIT && $urandom_range(4) != 0) pat = 8'($urandom_range(7));
      send(cmd, 3'($urandom_range(7)), 3'($urandom_range(7)), 3'($urandom_range(7)), pat,
           1'($urandom_range(1)));
   endfunction

   task automatic wait_idle();
      wait (cmds_accepted == cmds_queued && expected_words.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_count(count_cfg_type value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      count_mirror = value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // driver
   always @(negedge clock) begin
      cmd_item_type it;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            it = pending_cmds.pop_front();
            req_bus.valid   <= 1'b1;
            req_bus.cmd     <= it.cmd;
            req_bus.device  <= it.device;
            req_bus.row     <= it.row;
            req_bus.column  <= it.column;
            req_bus.pattern <= it.pattern;
            req_bus.flag    <= it.flag;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (stall_req != stall_ack) begin
         rsp_bus.ready <= 1'b0;
         stall_ack     <= stall_req;
         stall_left    <= LONG_STALL;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      chain_word_type exp_w;
      req_taken <= req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         predict_command({req_bus.cmd, req_bus.device, req_bus.row, req_bus.column,
                          req_bus.pattern, req_bus.flag});
         cmds_accepted++;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t ns: unexpected transaction, expected none, actual word %h dev %0d",
                     $time, rsp_bus.frame_word, rsp_bus.word_device);
            mismatches++;
         end else begin
            exp_w = expected_words.pop_front();
            check_field("frame_word", exp_w.word, rsp_bus.frame_word);
            check_field("word_device", 16'(exp_w.dev), 16'(rsp_bus.word_device));
            check_field("frame_end", 16'(exp_w.frame_end), 16'(rsp_bus.frame_end));
            check_field("last", 16'(exp_w.last), 16'(rsp_bus.last));
         end
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_write_data  = RESET_COUNT;
      req_bus.valid   = 1'b0;
      req_bus.cmd     = CMD_SET_LED;
      req_bus.device  = 3'd0;
      req_bus.row     = 3'd0;
      req_bus.column  = 3'd0;
      req_bus.pattern = 8'd0;
      req_bus.flag    = 1'b0;
      rsp_bus.ready   = 1'b0;
      req_taken       = 1'b0;
      count_mirror    = RESET_COUNT;
      foreach (shadow_mirror[i]) shadow_mirror[i] = 8'h00;
      cmds_queued   = 0;
      cmds_accepted = 0;
      mismatches    = 0;
      stall_req     = 0;
      stall_ack     = 0;
      stall_left    = 0;
      send_idle_pct = 22;
      recv_idle_pct = 78;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      send(CMD_SET_LED, 3'd0, 3'd0, 3'd0, 8'h00, 1'b1);
      send(CMD_SET_LED, 3'd7, 3'd7, 3'd7, 8'hFF, 1'b1);
      send(CMD_SET_ROW, 3'd3, 3'd5, 3'd0, 8'hA5, 1'b0);
      send(CMD_SET_LED, 3'd3, 3'd5, 3'd1, 8'h00, 1'b1);
      send(CMD_SET_LED, 3'd3, 3'd5, 3'd0, 8'h00, 1'b0);
      send(CMD_SET_ROW, 3'd7, 3'd7, 3'd7, 8'hFF, 1'b1);
      send(CMD_SET_ROW, 3'd0, 3'd0, 3'd0, 8'h00, 1'b0);
      send(CMD_SET_COLUMN, 3'd2, 3'd0, 3'd0, 8'h81, 1'b0);
      send(CMD_SET_COLUMN, 3'd2, 3'd0, 3'd7, 8'hFF, 1'b0);
      send(CMD_CLEAR, 3'd2, 3'd0, 3'd0, 8'h00, 1'b0);
      send(CMD_SHUTDOWN, 3'd1, 3'd0, 3'd0, 8'h00, 1'b1);
      send(CMD_SHUTDOWN, 3'd1, 3'd0, 3'd0, 8'h00, 1'b0);
      send(CMD_INTENSITY, 3'd4, 3'd0, 3'd0, 8'd0, 1'b0);
      send(CMD_INTENSITY, 3'd4, 3'd0, 3'd0, 8'd15, 1'b0);
      send(CMD_INTENSITY, 3'd4, 3'd0, 3'd0, 8'd16, 1'b0);
      send(CMD_SCAN_LIMIT, 3'd5, 3'd0, 3'd0, 8'd0, 1'b0);
      send(CMD_SCAN_LIMIT, 3'd5, 3'd0, 3'd0, 8'd7, 1'b0);
      send(CMD_SCAN_LIMIT, 3'd5, 3'd0, 3'd0, 8'd8, 1'b0);
      send(CMD_UNUSED, 3'd0, 3'd7, 3'd7, 8'hFF, 1'b1);
      wait_idle();

      write_count(4'd3);
      send(CMD_SET_ROW, 3'd3, 3'd1, 3'd0, 8'h3C, 1'b0);
      send(CMD_CLEAR, 3'd7, 3'd0, 3'd0, 8'h00, 1'b0);
      send(CMD_SET_LED, 3'd2, 3'd3, 3'd4, 8'h00, 1'b1);
      send(CMD_SET_COLUMN, 3'd0, 3'd0, 3'd3, 8'h5A, 1'b0);
      repeat (15) send_random();
      wait_idle();

      write_count(4'd8);
      repeat (15) send_random();
      wait_idle();

      send_idle_pct = 78;
      recv_idle_pct = 22;
      write_count(4'd1);
      repeat (10) send_random();
      wait_idle();
      write_count(4'd5);
      repeat (15) send_random();
      wait_idle();
      write_count(4'd0);
      repeat (8) send_random();
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_count(4'd15);
      stall_req++;
      repeat (12) send_random();
      wait_idle();
      write_count(4'd8);
      repeat (12) send_random();
      wait_idle();

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/lmcfw_pkg.sv
hdl/lmcfw_ifs.sv
hdl/lmcfw_shadow.sv
hdl/lmcfw_frame_emit.sv
hdl/led_matrix_chain_frame_writer.sv
bench/tb_led_matrix_chain_frame_writer.sv
